>>> src/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the card scan sequencer.
// ----------------------------------------------------------------------------
package css_pkg;

    // Command codes on the result beat
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_REQUEST  = 2'd1;
    localparam logic [1:0] CMD_ANTICOLL = 2'd2;
    localparam logic [1:0] CMD_HALT     = 2'd3;

    // Sequencer phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_REQ  = 2'd1;
    localparam logic [1:0] PH_ANTI = 2'd2;

    // Input item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_SCAN_INTERVAL    = 2'd0;
    localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_HOLD_TIME        = 2'd2;

    // Reader status masks
    localparam logic [7:0] IRQ_DONE_MASK = 8'h30;
    localparam logic [7:0] ERR_MASK      = 8'h1B;
    localparam logic [7:0] MIN_ID_BYTES  = 8'd5;

    // Register reset values (milliseconds)
    localparam logic [15:0] RST_SCAN_INTERVAL    = 16'd100;
    localparam logic [15:0] RST_RESPONSE_TIMEOUT = 16'd25;
    localparam logic [15:0] RST_HOLD_TIME        = 16'd500;

    typedef struct packed {
        logic [15:0] scan_interval;
        logic [15:0] response_timeout;
        logic [15:0] hold_time;
    } cfg_t;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [7:0]  irq_status;
        logic [7:0]  error_status;
        logic [7:0]  fifo_level;
        logic [31:0] id_bytes;
        logic [7:0]  check_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  seq_phase;
        logic [31:0] wait_start;
        logic [31:0] last_scan_start;
        logic [31:0] stored_id;
        logic [31:0] last_seen_time;
        logic        new_card_flag;
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic        new_card;
        logic [31:0] card_id;
        logic [1:0]  phase;
    } result_t;

endpackage

>>> src/css_cfg_regs.sv
// ----------------------------------------------------------------------------
// css_cfg_regs
// Configuration register file: scan interval, response timeout, hold time.
// ----------------------------------------------------------------------------
module css_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output css_pkg::cfg_t     cfg
);

    css_pkg::cfg_t cfg_reg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_interval    <= css_pkg::RST_SCAN_INTERVAL;
            cfg_reg.response_timeout <= css_pkg::RST_RESPONSE_TIMEOUT;
            cfg_reg.hold_time        <= css_pkg::RST_HOLD_TIME;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                css_pkg::REG_SCAN_INTERVAL:    cfg_reg.scan_interval    <= cfg_data;
                css_pkg::REG_RESPONSE_TIMEOUT: cfg_reg.response_timeout <= cfg_data;
                css_pkg::REG_HOLD_TIME:        cfg_reg.hold_time        <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/css_step.sv
// ----------------------------------------------------------------------------
// css_step
// Next-state and result logic for one item of the card poll sequencer.
// ----------------------------------------------------------------------------
module css_step (
    input  css_pkg::item_t    item,
    input  css_pkg::state_t   state,
    input  css_pkg::cfg_t     cfg,
    output css_pkg::state_t   state_next,
    output css_pkg::result_t  result
);

    logic [31:0] scan_age;
    logic [31:0] wait_age;
    logic [31:0] seen_age;
    logic        scan_due;
    logic        wait_expired;
    logic        hold_expired;
    logic        reply_done;
    logic        reply_error;
    logic        id_check_ok;
    logic [7:0]  id_xor;
    logic [1:0]  command;
    logic        new_card;

    // Wrapping time differences against the stored timestamps
    assign scan_age     = item.now_ms - state.last_scan_start;
    assign wait_age     = item.now_ms - state.wait_start;
    assign seen_age     = item.now_ms - state.last_seen_time;
    assign scan_due     = scan_age >= {16'd0, cfg.scan_interval};
    assign wait_expired = wait_age >= {16'd0, cfg.response_timeout};
    assign hold_expired = seen_age >= {16'd0, cfg.hold_time};

    // Reader status decode and ID check byte
    assign reply_done  = (item.irq_status & css_pkg::IRQ_DONE_MASK) != 8'd0;
    assign reply_error = (item.error_status & css_pkg::ERR_MASK) != 8'd0;
    assign id_xor      = item.id_bytes[31:24] ^ item.id_bytes[23:16]
                       ^ item.id_bytes[15:8]  ^ item.id_bytes[7:0];
    assign id_check_ok = !reply_error && (item.fifo_level >= css_pkg::MIN_ID_BYTES)
                       && (id_xor == item.check_byte);

    // Advance the sequencer on a tick; a read returns and clears the new-card flag
    always_comb
    begin
        state_next = state;
        command    = css_pkg::CMD_NONE;
        new_card   = 1'b0;
        if (item.op == css_pkg::OP_READ)
        begin
            new_card                 = state.new_card_flag;
            state_next.new_card_flag = 1'b0;
        end
        else
        begin
            unique case (state.seq_phase)
                css_pkg::PH_IDLE:
                begin
                    if (hold_expired)
                    begin
                        state_next.stored_id = 32'd0;
                    end
                    if (scan_due)
                    begin
                        state_next.last_scan_start = item.now_ms;
                        state_next.wait_start      = item.now_ms;
                        state_next.seq_phase       = css_pkg::PH_REQ;
                        command                    = css_pkg::CMD_REQUEST;
                    end
                end
                css_pkg::PH_REQ:
                begin
                    priority if (wait_expired)
                    begin
                        state_next.seq_phase = css_pkg::PH_IDLE;
                    end
                    else if (reply_done)
                    begin
                        if (!reply_error)
                        begin
                            state_next.wait_start = item.now_ms;
                            state_next.seq_phase  = css_pkg::PH_ANTI;
                            command               = css_pkg::CMD_ANTICOLL;
                        end
                        else
                        begin
                            state_next.seq_phase = css_pkg::PH_IDLE;
                        end
                    end
                end
                css_pkg::PH_ANTI:
                begin
                    priority if (wait_expired)
                    begin
                        state_next.seq_phase = css_pkg::PH_IDLE;
                    end
                    else if (reply_done)
                    begin
                        if (id_check_ok)
                        begin
                            // A repeat card only refreshes the sighting time
                            if (item.id_bytes != state.stored_id)
                            begin
                                state_next.stored_id     = item.id_bytes;
                                state_next.new_card_flag = 1'b1;
                            end
                            state_next.last_seen_time = item.now_ms;
                            command                   = css_pkg::CMD_HALT;
                        end
                        state_next.seq_phase = css_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    state_next.seq_phase = css_pkg::PH_IDLE;
                end
            endcase
        end
    end

    assign result.command  = command;
    assign result.new_card = new_card;
    assign result.card_id  = state_next.stored_id;
    assign result.phase    = state_next.seq_phase;

endmodule

>>> src/card_scan_sequencer_unit.sv
// ----------------------------------------------------------------------------
// card_scan_sequencer_unit
// Contactless card poll sequencer: request, anticollision and halt commands
// from reader status ticks, with stored card ID and new-card flag.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata (reader status), s_tuser (op)
//  m_*       out        m_tvalid/m_tready  m_tdata (command, flag, id, phase)
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
//  One beat per cycle sustained while m_tready is high: beat registered at the
//  input, then step logic into the result register, which drives m_tdata.
//  Sequencer state updates when a beat leaves the input register.
//  A stalled result holds the result register and then the input register;
//  s_tready stays high while the result drains. Reset is asynchronous and
//  restores the register and state reset values; no clearing pass.
// ----------------------------------------------------------------------------
module card_scan_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_ms[31:0], irq_status[39:32], error_status[47:40], fifo_level[55:48],
    // id_bytes[87:56], check_byte[95:88]
    input  logic [95:0]  s_tdata,
    // op[0]
    input  logic         s_tuser,
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // command[1:0], new_card[2], card_id[34:3], phase[36:35], zero[39:37]
    output logic [39:0]  m_tdata,
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    css_pkg::cfg_t    cfg;
    css_pkg::item_t   item_reg;
    logic             item_valid_reg;
    css_pkg::state_t  state_reg;
    css_pkg::state_t  state_next;
    css_pkg::result_t result_next;
    css_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic             advance;

    css_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    css_step u_step (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Move the held beat into the result register when it is free
    assign advance  = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.op           <= s_tuser;
            item_reg.now_ms       <= s_tdata[31:0];
            item_reg.irq_status   <= s_tdata[39:32];
            item_reg.error_status <= s_tdata[47:40];
            item_reg.fifo_level   <= s_tdata[55:48];
            item_reg.id_bytes     <= s_tdata[87:56];
            item_reg.check_byte   <= s_tdata[95:88];
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seq_phase       <= css_pkg::PH_IDLE;
            state_reg.wait_start      <= 32'd0;
            state_reg.last_scan_start <= 32'd0;
            state_reg.stored_id       <= 32'd0;
            state_reg.last_seen_time  <= 32'd0;
            state_reg.new_card_flag   <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {3'd0, result_reg.phase, result_reg.card_id,
                       result_reg.new_card, result_reg.command};

endmodule
